// ===== sv/pga_pkg.sv =====
// Package for the pairwise gravity acceleration block: widths, register
// indices, reset values, arithmetic types and the word structs.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pga_pkg;

    // Field and datapath widths
    localparam int POS_BITS    = 16;
    localparam int FRAC_BITS   = 32;
    localparam int MASS_W      = 16;
    localparam int MSUM_W      = MASS_W + 1;
    localparam int DIFF_W      = POS_BITS + 1;
    localparam int ABS_W       = POS_BITS;
    localparam int DIST_W      = 2 * ABS_W + 1;
    localparam int PROD_W      = ABS_W + MSUM_W;
    localparam int COEFF_W     = 17;
    localparam int COEFF_SHIFT = 16;
    localparam int THR_W       = 34;
    localparam int SCALE_W     = 20;
    localparam int MUL_W       = COEFF_W + 7;
    localparam int FM_W        = SCALE_W + MUL_W;
    localparam int FM_LO_W     = FM_W / 2;
    localparam int FM_HI_W     = FM_W - FM_LO_W;
    localparam int NUM0_W      = PROD_W + FM_W;
    localparam int DD_W        = 2 * DIST_W;
    localparam int Q_W         = MASS_W;
    localparam int DEN_W       = DD_W + Q_W;
    localparam int NUM_W       = NUM0_W + FRAC_BITS;
    localparam int OUT_W       = 48;
    localparam int QUOT_W      = OUT_W;
    localparam int CMP_W       = DEN_W + QUOT_W;
    localparam int LANES       = 4;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = THR_W;

    // Arithmetic types
    typedef logic [DIFF_W-1:0]          diff_t;
    typedef logic [ABS_W-1:0]           abs_t;
    typedef logic [MSUM_W-1:0]          msum_t;
    typedef logic [DIST_W-1:0]          dist_t;
    typedef logic [PROD_W-1:0]          prod_t;
    typedef logic [MUL_W-1:0]           mul_t;
    typedef logic [SCALE_W-1:0]         scale_t;
    typedef logic [THR_W-1:0]           thr_t;
    typedef logic [FM_W-1:0]            fm_t;
    typedef logic [PROD_W+FM_LO_W-1:0]  pplo_t;
    typedef logic [PROD_W+FM_HI_W-1:0]  pphi_t;
    typedef logic [NUM0_W-1:0]          num0_t;
    typedef logic [DD_W-1:0]            dd_t;
    typedef logic [DIST_W+Q_W-1:0]      dpart_t;
    typedef logic [Q_W-1:0]             q_t;
    typedef logic [DEN_W-1:0]           den_t;
    typedef logic [NUM_W-1:0]           num_t;
    typedef logic [CMP_W-1:0]           cmp_t;
    typedef logic [QUOT_W-1:0]          quot_t;

    // Mode codes; the unused code behaves as the mutual mode
    localparam logic [MODE_W-1:0] MODE_STAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MUTUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PLANET = 2'd2;

    // Register indices
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd3;

    // Reset values
    localparam logic [MODE_W-1:0]  MODE_RESET      = MODE_MUTUAL;
    localparam logic [COEFF_W-1:0] COEFF_RESET     = 17'd32768;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 34'd1000000;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 20'd10000;

    // Constant factors
    localparam logic [MUL_W-1:0] PLANET_MUL = 24'd100;
    localparam logic [Q_W-1:0]   STAR_DIV   = 16'd100;

    // Saturation limits of the result magnitude
    localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [POS_BITS-1:0] planet_x;
        logic signed [POS_BITS-1:0] planet_y;
        logic signed [POS_BITS-1:0] star_x;
        logic signed [POS_BITS-1:0] star_y;
        logic [MASS_W-1:0]          planet_mass;
        logic [MASS_W-1:0]          star_mass;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] planet_dax;
        logic signed [OUT_W-1:0] planet_day;
        logic signed [OUT_W-1:0] star_dax;
        logic signed [OUT_W-1:0] star_day;
        logic                    coincident;
        logic                    saturated;
    } out_item_t;

    // Per-word side information carried alongside the divider lanes.
    // Lane order: planet x, planet y, star x, star y.
    typedef struct packed {
        logic             coin;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] kill;
    } pga_tag_t;

endpackage

`default_nettype wire

// ===== sv/pairwise_gravity_accel.sv =====
// Top level of the pairwise gravity acceleration block: configuration
// registers, the multiplier front end and the output stage. Uses pga_pkg
// and pga_divider.
//
// Usage
// - Input channel (in_valid/in_ready/in_data) takes one body pair per word;
//   output channel (out_valid/out_ready/out_data) gives the four signed
//   Q16.32 increments with the coincident and saturated flags.
// - Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 mode, 1 coefficient, 2 falloff threshold, 3 falloff scale) at once.
//   Write only while no word is in flight.
// - Throughput: one word per cycle while the receiver keeps up. From acceptance
//   to out_valid a word passes six multiplier stages, the divider's overflow stage
//   plus one stage per quotient bit (48) and the output register.
// - Each stage holds its word while the stage after it is full, so empty
//   slots close up and in_ready stays high while the pipeline has room,
//   even when the receiver stalls. No word is dropped or repeated.
// - Reset clears all valid bits and loads the configuration defaults
//   (mode 1, coefficient 0.5, threshold 1000000, scale 10000).
`default_nettype none

module pairwise_gravity_accel (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pga_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pga_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire pga_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output pga_pkg::out_item_t                   out_data
);

    // Configuration registers
    logic [pga_pkg::MODE_W-1:0]  mode_reg;
    logic [pga_pkg::COEFF_W-1:0] coeff_reg;
    pga_pkg::thr_t               thr_reg;
    pga_pkg::scale_t             scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pga_pkg::MODE_RESET;
            coeff_reg <= pga_pkg::COEFF_RESET;
            thr_reg   <= pga_pkg::THRESHOLD_RESET;
            scale_reg <= pga_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pga_pkg::REG_MODE:      mode_reg  <= cfg_wdata[pga_pkg::MODE_W-1:0];
                pga_pkg::REG_COEFF:     coeff_reg <= cfg_wdata[pga_pkg::COEFF_W-1:0];
                pga_pkg::REG_THRESHOLD: thr_reg   <= cfg_wdata[pga_pkg::THR_W-1:0];
                pga_pkg::REG_SCALE:     scale_reg <= cfg_wdata[pga_pkg::SCALE_W-1:0];
                default:                mode_reg  <= mode_reg;
            endcase
        end
    end

    // Front-end stage valid bits and the shared advance chain
    logic [6:1] fv_reg;
    logic [6:1] fen;
    logic       div_in_ready;

    assign fen[6]   = !fv_reg[6] || div_in_ready;
    assign fen[5]   = !fv_reg[5] || fen[6];
    assign fen[4]   = !fv_reg[4] || fen[5];
    assign fen[3]   = !fv_reg[3] || fen[4];
    assign fen[2]   = !fv_reg[2] || fen[3];
    assign fen[1]   = !fv_reg[1] || fen[2];
    assign in_ready = fen[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            if (fen[1]) fv_reg[1] <= in_valid;
            if (fen[2]) fv_reg[2] <= fv_reg[1];
            if (fen[3]) fv_reg[3] <= fv_reg[2];
            if (fen[4]) fv_reg[4] <= fv_reg[3];
            if (fen[5]) fv_reg[5] <= fv_reg[4];
            if (fen[6]) fv_reg[6] <= fv_reg[5];
        end
    end

    // Stage 1: position differences, their magnitudes and signs, mass sum
    pga_pkg::diff_t dx_w, dy_w, adx_w, ady_w;
    pga_pkg::abs_t  ax1_reg, ay1_reg;
    logic [pga_pkg::LANES-1:0] neg1_next, neg1_reg;
    pga_pkg::msum_t msum1_reg;
    logic [pga_pkg::MASS_W-1:0] m1_1_reg, m2_1_reg;

    always_comb
    begin
        dx_w  = {in_data.star_x[pga_pkg::POS_BITS-1], in_data.star_x}
              - {in_data.planet_x[pga_pkg::POS_BITS-1], in_data.planet_x};
        dy_w  = {in_data.star_y[pga_pkg::POS_BITS-1], in_data.star_y}
              - {in_data.planet_y[pga_pkg::POS_BITS-1], in_data.planet_y};
        adx_w = dx_w[pga_pkg::DIFF_W-1] ? (~dx_w + 1'b1) : dx_w;
        ady_w = dy_w[pga_pkg::DIFF_W-1] ? (~dy_w + 1'b1) : dy_w;
        // Planet moves toward the star, the star the opposite way
        neg1_next[0] = dx_w[pga_pkg::DIFF_W-1];
        neg1_next[1] = dy_w[pga_pkg::DIFF_W-1];
        neg1_next[2] = !dx_w[pga_pkg::DIFF_W-1] && (dx_w != '0);
        neg1_next[3] = !dy_w[pga_pkg::DIFF_W-1] && (dy_w != '0);
    end

    always_ff @(posedge clk)
    begin
        if (fen[1])
        begin
            ax1_reg   <= adx_w[pga_pkg::ABS_W-1:0];
            ay1_reg   <= ady_w[pga_pkg::ABS_W-1:0];
            neg1_reg  <= neg1_next;
            msum1_reg <= {1'b0, in_data.planet_mass} + {1'b0, in_data.star_mass};
            m1_1_reg  <= in_data.planet_mass;
            m2_1_reg  <= in_data.star_mass;
        end
    end

    // Stage 2: squared distance and component times mass sum
    pga_pkg::dist_t d2_reg;
    pga_pkg::prod_t px2_reg, py2_reg;
    logic [pga_pkg::LANES-1:0] neg2_reg;
    logic [pga_pkg::MASS_W-1:0] m1_2_reg, m2_2_reg;

    always_ff @(posedge clk)
    begin
        if (fen[2])
        begin
            d2_reg   <= pga_pkg::dist_t'(ax1_reg) * pga_pkg::dist_t'(ax1_reg)
                      + pga_pkg::dist_t'(ay1_reg) * pga_pkg::dist_t'(ay1_reg);
            px2_reg  <= pga_pkg::prod_t'(ax1_reg) * pga_pkg::prod_t'(msum1_reg);
            py2_reg  <= pga_pkg::prod_t'(ay1_reg) * pga_pkg::prod_t'(msum1_reg);
            neg2_reg <= neg1_reg;
            m1_2_reg <= m1_1_reg;
            m2_2_reg <= m2_1_reg;
        end
    end

    // Stage 3: falloff decision and per-mode factors
    logic           far3, coin3, sh3_next;
    pga_pkg::mul_t  mulp3_next, muls3_next;
    pga_pkg::q_t    qp3_next, qs3_next;

    always_comb
    begin
        far3  = pga_pkg::thr_t'(d2_reg) > thr_reg;
        coin3 = d2_reg == '0;
        case (mode_reg)
            pga_pkg::MODE_STAR:
            begin
                mulp3_next = pga_pkg::mul_t'(1);
                muls3_next = pga_pkg::mul_t'(1);
                qp3_next   = pga_pkg::q_t'(1);
                qs3_next   = pga_pkg::STAR_DIV;
                sh3_next   = 1'b0;
            end
            pga_pkg::MODE_PLANET:
            begin
                mulp3_next = pga_pkg::mul_t'(coeff_reg) * pga_pkg::PLANET_MUL;
                muls3_next = pga_pkg::mul_t'(coeff_reg) * pga_pkg::PLANET_MUL;
                qp3_next   = m1_2_reg;
                qs3_next   = m1_2_reg;
                sh3_next   = 1'b1;
            end
            default:
            begin
                mulp3_next = pga_pkg::mul_t'(coeff_reg);
                muls3_next = pga_pkg::mul_t'(coeff_reg);
                qp3_next   = m1_2_reg;
                qs3_next   = m2_2_reg;
                sh3_next   = 1'b1;
            end
        endcase
    end

    pga_pkg::dist_t  d3_reg, g3_reg;
    pga_pkg::scale_t f3_reg;
    pga_pkg::prod_t  px3_reg, py3_reg;
    pga_pkg::mul_t   mulp3_reg, muls3_reg;
    pga_pkg::q_t     qp3_reg, qs3_reg;
    logic            sh3_reg;
    pga_pkg::pga_tag_t tag3_reg;

    always_ff @(posedge clk)
    begin
        if (fen[3])
        begin
            d3_reg        <= d2_reg;
            g3_reg        <= far3 ? d2_reg : pga_pkg::dist_t'(1);
            f3_reg        <= far3 ? scale_reg : pga_pkg::scale_t'(1);
            px3_reg       <= px2_reg;
            py3_reg       <= py2_reg;
            mulp3_reg     <= mulp3_next;
            muls3_reg     <= muls3_next;
            qp3_reg       <= qp3_next;
            qs3_reg       <= qs3_next;
            sh3_reg       <= sh3_next;
            tag3_reg.coin <= coin3;
            tag3_reg.neg  <= neg2_reg;
            tag3_reg.kill <= {{2{coin3 || (qs3_next == '0)}},
                              {2{coin3 || (qp3_next == '0)}}};
        end
    end

    // Stage 4: falloff scale times mode factor, squared distance product
    pga_pkg::fm_t fmp4_reg, fms4_reg;
    pga_pkg::dd_t dd4_reg;
    pga_pkg::prod_t px4_reg, py4_reg;
    pga_pkg::q_t    qp4_reg, qs4_reg;
    logic           sh4_reg;
    pga_pkg::pga_tag_t tag4_reg;

    always_ff @(posedge clk)
    begin
        if (fen[4])
        begin
            fmp4_reg <= pga_pkg::fm_t'(f3_reg) * pga_pkg::fm_t'(mulp3_reg);
            fms4_reg <= pga_pkg::fm_t'(f3_reg) * pga_pkg::fm_t'(muls3_reg);
            dd4_reg  <= pga_pkg::dd_t'(d3_reg) * pga_pkg::dd_t'(g3_reg);
            px4_reg  <= px3_reg;
            py4_reg  <= py3_reg;
            qp4_reg  <= qp3_reg;
            qs4_reg  <= qs3_reg;
            sh4_reg  <= sh3_reg;
            tag4_reg <= tag3_reg;
        end
    end

    // Stage 5: partial products of numerators and denominators
    pga_pkg::prod_t comp4 [pga_pkg::LANES];
    pga_pkg::fm_t   fm4   [pga_pkg::LANES];
    pga_pkg::pplo_t lo5_reg [pga_pkg::LANES];
    pga_pkg::pphi_t hi5_reg [pga_pkg::LANES];
    pga_pkg::dpart_t dlp5_reg, dhp5_reg, dls5_reg, dhs5_reg;
    logic            sh5_reg;
    pga_pkg::pga_tag_t tag5_reg;

    always_comb
    begin
        comp4[0] = px4_reg;
        comp4[1] = py4_reg;
        comp4[2] = px4_reg;
        comp4[3] = py4_reg;
        fm4[0]   = fmp4_reg;
        fm4[1]   = fmp4_reg;
        fm4[2]   = fms4_reg;
        fm4[3]   = fms4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fen[5])
        begin
            for (int l = 0; l < pga_pkg::LANES; l++)
            begin
                lo5_reg[l] <= pga_pkg::pplo_t'(comp4[l])
                            * pga_pkg::pplo_t'(fm4[l][pga_pkg::FM_LO_W-1:0]);
                hi5_reg[l] <= pga_pkg::pphi_t'(comp4[l])
                            * pga_pkg::pphi_t'(fm4[l][pga_pkg::FM_W-1:pga_pkg::FM_LO_W]);
            end
            dlp5_reg <= pga_pkg::dpart_t'(dd4_reg[pga_pkg::DIST_W-1:0])
                      * pga_pkg::dpart_t'(qp4_reg);
            dhp5_reg <= pga_pkg::dpart_t'(dd4_reg[pga_pkg::DD_W-1:pga_pkg::DIST_W])
                      * pga_pkg::dpart_t'(qp4_reg);
            dls5_reg <= pga_pkg::dpart_t'(dd4_reg[pga_pkg::DIST_W-1:0])
                      * pga_pkg::dpart_t'(qs4_reg);
            dhs5_reg <= pga_pkg::dpart_t'(dd4_reg[pga_pkg::DD_W-1:pga_pkg::DIST_W])
                      * pga_pkg::dpart_t'(qs4_reg);
            sh5_reg  <= sh4_reg;
            tag5_reg <= tag4_reg;
        end
    end

    // Stage 6: sum the partial products and align the fraction
    pga_pkg::num0_t num0_6 [pga_pkg::LANES];
    pga_pkg::den_t  denp6, dens6;
    logic [pga_pkg::LANES-1:0][pga_pkg::NUM_W-1:0] num6_reg;
    logic [pga_pkg::LANES-1:0][pga_pkg::DEN_W-1:0] den6_reg;
    pga_pkg::pga_tag_t tag6_reg;

    always_comb
    begin
        for (int l = 0; l < pga_pkg::LANES; l++)
        begin
            num0_6[l] = pga_pkg::num0_t'(lo5_reg[l])
                      + (pga_pkg::num0_t'(hi5_reg[l]) << pga_pkg::FM_LO_W);
        end
        denp6 = pga_pkg::den_t'(dlp5_reg) + (pga_pkg::den_t'(dhp5_reg) << pga_pkg::DIST_W);
        dens6 = pga_pkg::den_t'(dls5_reg) + (pga_pkg::den_t'(dhs5_reg) << pga_pkg::DIST_W);
    end

    always_ff @(posedge clk)
    begin
        if (fen[6])
        begin
            for (int l = 0; l < pga_pkg::LANES; l++)
            begin
                // The coefficient's 2^16 scale cancels part of the fraction shift
                num6_reg[l] <= sh5_reg
                    ? (pga_pkg::num_t'(num0_6[l])
                       << (pga_pkg::FRAC_BITS - pga_pkg::COEFF_SHIFT))
                    : (pga_pkg::num_t'(num0_6[l]) << pga_pkg::FRAC_BITS);
            end
            den6_reg[0] <= denp6;
            den6_reg[1] <= denp6;
            den6_reg[2] <= dens6;
            den6_reg[3] <= dens6;
            tag6_reg    <= tag5_reg;
        end
    end

    // Quotients
    logic div_out_valid, div_out_ready;
    logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] div_quot;
    logic [pga_pkg::LANES-1:0] div_over;
    pga_pkg::pga_tag_t div_tag;

    pga_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv_reg[6]),
        .in_ready  (div_in_ready),
        .in_num    (num6_reg),
        .in_den    (den6_reg),
        .in_tag    (tag6_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_quot  (div_quot),
        .out_over  (div_over),
        .out_tag   (div_tag)
    );

    // Output stage: saturate, apply sign, force zero where required
    logic out_valid_reg;
    pga_pkg::out_item_t out_reg;
    logic [pga_pkg::OUT_W-1:0] lim_o [pga_pkg::LANES];
    logic [pga_pkg::OUT_W-1:0] mag_o [pga_pkg::LANES];
    logic [pga_pkg::OUT_W-1:0] val_o [pga_pkg::LANES];
    logic [pga_pkg::LANES-1:0] sat_o;
    pga_pkg::out_item_t out_next;

    assign div_out_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int l = 0; l < pga_pkg::LANES; l++)
        begin
            lim_o[l] = div_tag.neg[l] ? pga_pkg::NEG_LIMIT : pga_pkg::POS_LIMIT;
            sat_o[l] = !div_tag.kill[l] && (div_over[l] || (div_quot[l] > lim_o[l]));
            if (div_tag.kill[l])
            begin
                mag_o[l] = '0;
            end
            else if (sat_o[l])
            begin
                mag_o[l] = lim_o[l];
            end
            else
            begin
                mag_o[l] = div_quot[l];
            end
            val_o[l] = div_tag.neg[l] ? (~mag_o[l] + 1'b1) : mag_o[l];
        end
        out_next.planet_dax = val_o[0];
        out_next.planet_day = val_o[1];
        out_next.star_dax   = val_o[2];
        out_next.star_day   = val_o[3];
        out_next.coincident = div_tag.coin;
        out_next.saturated  = |sat_o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready && div_out_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Coincident bodies give zero increments and never a saturation flag
    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.coincident |->
            out_data.planet_dax == '0 && out_data.planet_day == '0 &&
            out_data.star_dax == '0 && out_data.star_day == '0 &&
            !out_data.saturated)
        else $error("coincident word carries non-zero increments");

    // Planet and star are pushed in opposite directions along each axis
    a_opposite_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            !(out_data.planet_dax[pga_pkg::OUT_W-1] && out_data.star_dax[pga_pkg::OUT_W-1]) &&
            !(out_data.planet_day[pga_pkg::OUT_W-1] && out_data.star_day[pga_pkg::OUT_W-1]))
        else $error("planet and star increments share a negative sign");

    // A divider word held back by a full output register is not lost
    a_divider_hold: assert property (@(posedge clk) disable iff (!rst_n)
        div_out_valid && !div_out_ready |=> div_out_valid)
        else $error("divider word dropped while output stage was full");

endmodule

`default_nettype wire

// ===== sv/pga_divider.sv =====
// Pipelined restoring divider for four lanes, one quotient bit per stage,
// with an overflow check up front. Uses pga_pkg for widths and the tag type.
`default_nettype none

module pga_divider (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic [pga_pkg::LANES-1:0][pga_pkg::NUM_W-1:0] in_num,
    input  wire logic [pga_pkg::LANES-1:0][pga_pkg::DEN_W-1:0] in_den,
    input  wire pga_pkg::pga_tag_t                        in_tag,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] out_quot,
    output logic [pga_pkg::LANES-1:0]                     out_over,
    output pga_pkg::pga_tag_t                             out_tag
);

    // Stage registers: stage 0 holds the overflow check, stage k quotient bit QUOT_W-k
    logic [pga_pkg::LANES-1:0][pga_pkg::NUM_W-1:0]  rem_reg  [pga_pkg::QUOT_W+1];
    logic [pga_pkg::LANES-1:0][pga_pkg::DEN_W-1:0]  den_reg  [pga_pkg::QUOT_W+1];
    logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] quot_reg [pga_pkg::QUOT_W+1];
    logic [pga_pkg::LANES-1:0]                      over_reg [pga_pkg::QUOT_W+1];
    pga_pkg::pga_tag_t                              tag_reg  [pga_pkg::QUOT_W+1];
    logic [pga_pkg::QUOT_W:0]                       valid_reg;
    logic [pga_pkg::QUOT_W+1:0]                     en;

    // A stage moves on when it is empty or the stage after it moves on
    assign en[pga_pkg::QUOT_W+1] = out_ready;
    genvar k;
    generate
        for (k = 0; k <= pga_pkg::QUOT_W; k++)
        begin : g_en
            assign en[k] = !valid_reg[k] || en[k+1];
        end
    endgenerate
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s <= pga_pkg::QUOT_W; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // Overflow check: the quotient does not fit in the result width
    logic [pga_pkg::LANES-1:0] over_next;
    always_comb
    begin
        for (int l = 0; l < pga_pkg::LANES; l++)
        begin
            over_next[l] = pga_pkg::cmp_t'(in_num[l])
                           >= (pga_pkg::cmp_t'(in_den[l]) << pga_pkg::QUOT_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quot_reg[0] <= '0;
            over_reg[0] <= over_next;
            tag_reg[0]  <= in_tag;
        end
    end

    // One compare and subtract per stage, most significant bit first
    generate
        for (k = 1; k <= pga_pkg::QUOT_W; k++)
        begin : g_stage
            localparam int BIT = pga_pkg::QUOT_W - k;
            logic [pga_pkg::LANES-1:0][pga_pkg::NUM_W-1:0]  rem_next;
            logic [pga_pkg::LANES-1:0][pga_pkg::QUOT_W-1:0] quot_next;
            pga_pkg::cmp_t trial [pga_pkg::LANES];
            logic [pga_pkg::LANES-1:0] ge;

            always_comb
            begin
                for (int l = 0; l < pga_pkg::LANES; l++)
                begin
                    trial[l] = pga_pkg::cmp_t'(den_reg[k-1][l]) << BIT;
                    ge[l] = pga_pkg::cmp_t'(rem_reg[k-1][l]) >= trial[l];
                    rem_next[l] = ge[l]
                        ? pga_pkg::num_t'(pga_pkg::cmp_t'(rem_reg[k-1][l]) - trial[l])
                        : rem_reg[k-1][l];
                    quot_next[l] = quot_reg[k-1][l];
                    quot_next[l][BIT] = ge[l];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_reg[k-1];
                    quot_reg[k] <= quot_next;
                    over_reg[k] <= over_reg[k-1];
                    tag_reg[k]  <= tag_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[pga_pkg::QUOT_W];
    assign out_quot  = quot_reg[pga_pkg::QUOT_W];
    assign out_over  = over_reg[pga_pkg::QUOT_W];
    assign out_tag   = tag_reg[pga_pkg::QUOT_W];

endmodule

`default_nettype wire

// ===== tb/pairwise_gravity_accel_check.sv =====
// Checker for the pairwise gravity acceleration block: watches the
// configuration port and both word channels, predicts each result and compares.
// Depends on pga_pkg.
`timescale 1ns / 1ps

module pairwise_gravity_accel_check
    import pga_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    output int                   mismatches,
    output int                   in_flight
);

    // Shadow copy of the configuration registers.
    logic [MODE_W-1:0]  sh_mode;
    logic [COEFF_W-1:0] sh_coeff;
    logic [THR_W-1:0]   sh_thr;
    logic [SCALE_W-1:0] sh_scale;

    out_item_t accel_queue[$];

    // One increment: exact rational value, truncated toward zero, then clipped.
    function automatic logic [OUT_W-1:0] lane_accel(
        logic [63:0] comp, logic neg, logic [63:0] msum, logic [63:0] dsq,
        logic far, logic [63:0] mul1, logic [63:0] div1, logic [63:0] div2,
        inout logic sat);
        logic [191:0] acc;
        logic [191:0] lim;
        logic [47:0]  mag;
        if (div2 == 0 || comp == 0)
            return '0;
        acc = comp;
        acc = acc * msum;
        if (far)
            acc = acc * sh_scale;
        acc = acc * mul1;
        acc = acc << FRAC_BITS;
        acc = acc / dsq;
        if (far)
            acc = acc / dsq;
        acc = acc / div1;
        acc = acc / div2;
        lim = neg ? 192'(NEG_LIMIT) : 192'(POS_LIMIT);
        if (acc > lim)
        begin
            acc = lim;
            sat = 1'b1;
        end
        mag = acc[47:0];
        return neg ? -mag : mag;
    endfunction

    // Expected result of one body pair under the current configuration.
    function automatic out_item_t predict_accel(in_item_t w);
        out_item_t   r;
        longint      dx, dy;
        logic [63:0] ax, ay, dsq, msum, m1, m2;
        logic [63:0] pmul, pdiv1, pdiv2, smul, sdiv1, sdiv2;
        logic        far, sat;
        r = '0;
        sat = 1'b0;
        dx = longint'(w.star_x) - longint'(w.planet_x);
        dy = longint'(w.star_y) - longint'(w.planet_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        dsq = ax * ax + ay * ay;
        m1 = w.planet_mass;
        m2 = w.star_mass;
        msum = m1 + m2;
        if (dsq == 0)
        begin
            r.coincident = 1'b1;
            return r;
        end
        far = dsq > 64'(sh_thr);
        if (sh_mode == MODE_STAR)
        begin
            pmul = 1; pdiv1 = 1; pdiv2 = 1;
            smul = 1; sdiv1 = 100; sdiv2 = 1;
        end
        else if (sh_mode == MODE_PLANET)
        begin
            pmul = 64'(sh_coeff) * 100; pdiv1 = 65536; pdiv2 = m1;
            smul = pmul; sdiv1 = 65536; sdiv2 = m1;
        end
        else
        begin
            pmul = sh_coeff; pdiv1 = 65536; pdiv2 = m1;
            smul = sh_coeff; sdiv1 = 65536; sdiv2 = m2;
        end
        r.planet_dax = lane_accel(ax, dx < 0, msum, dsq, far, pmul, pdiv1, pdiv2, sat);
        r.planet_day = lane_accel(ay, dy < 0, msum, dsq, far, pmul, pdiv1, pdiv2, sat);
        r.star_dax   = lane_accel(ax, dx > 0, msum, dsq, far, smul, sdiv1, sdiv2, sat);
        r.star_day   = lane_accel(ay, dy > 0, msum, dsq, far, smul, sdiv1, sdiv2, sat);
        r.saturated  = sat;
        return r;
    endfunction

    // Track writes, predict on input words and compare on output words.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_w;
        if (!rst_n)
        begin
            sh_mode  <= MODE_RESET;
            sh_coeff <= COEFF_RESET;
            sh_thr   <= THRESHOLD_RESET;
            sh_scale <= SCALE_RESET;
            mismatches = 0;
            accel_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:      sh_mode  <= cfg_wdata[MODE_W-1:0];
                    REG_COEFF:     sh_coeff <= cfg_wdata[COEFF_W-1:0];
                    REG_THRESHOLD: sh_thr   <= cfg_wdata[THR_W-1:0];
                    REG_SCALE:     sh_scale <= cfg_wdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                accel_queue.push_back(predict_accel(in_data));
            if (out_valid && out_ready)
            begin
                if (accel_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word %h", $realtime, out_data);
                end
                else
                begin
                    exp_w = accel_queue.pop_front();
                    if (exp_w !== out_data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp pdx %h pdy %h sdx %h sdy %h c %b s %b",
                                     $realtime, exp_w.planet_dax, exp_w.planet_day,
                                     exp_w.star_dax, exp_w.star_day, exp_w.coincident,
                                     exp_w.saturated);
                            $display("%0t:          got pdx %h pdy %h sdx %h sdy %h c %b s %b",
                                     $realtime, out_data.planet_dax,
                                     out_data.planet_day, out_data.star_dax,
                                     out_data.star_day, out_data.coincident,
                                     out_data.saturated);
                        end
                    end
                end
            end
        end
        in_flight = accel_queue.size();
    end

endmodule

// ===== tb/pairwise_gravity_accel_test.sv =====
// Top of the pairwise gravity acceleration testbench: clock, reset, stimulus,
// receiver back-pressure and the verdict.
// Depends on pga_pkg, pairwise_gravity_accel and pairwise_gravity_accel_check.
`timescale 1ns / 1ps

module pairwise_gravity_accel_test;
    import pga_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    int                   mismatches;
    int                   in_flight;
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    logic                 hold_rx;
    int                   quiet_cycles;

    pairwise_gravity_accel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pairwise_gravity_accel_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, or one long hold-off when asked.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles in which no word moves.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pairwise_gravity_accel_test: done, errors");
            $finish;
        end
    end

    // Offer one word and hold it until taken, then maybe leave a gap.
    task automatic send_pair(in_item_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // One register write, after which the port is left idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t make_pair(int px, int py, int sx, int sy,
                                           int pm, int sm);
        in_item_t w;
        w.planet_x    = px[15:0];
        w.planet_y    = py[15:0];
        w.star_x      = sx[15:0];
        w.star_y      = sy[15:0];
        w.planet_mass = pm[15:0];
        w.star_mass   = sm[15:0];
        return w;
    endfunction

    // Random pair: mostly near bodies so the results stay in range.
    function automatic in_item_t random_pair();
        in_item_t w;
        int       span;
        w = in_item_t'({$urandom, $urandom, $urandom});
        case ($urandom_range(4))
            0: span = 0;
            1: span = 4;
            2: span = 100;
            3: span = 3000;
            default: span = -1;
        endcase
        if (span >= 0)
        begin
            w.star_x = w.planet_x + 16'($urandom_range(2 * span) - span);
            w.star_y = w.planet_y + 16'($urandom_range(2 * span) - span);
        end
        if ($urandom_range(1))
            w.planet_mass = 16'($urandom_range(1, 300));
        if ($urandom_range(1))
            w.star_mass = 16'($urandom_range(1, 300));
        return w;
    endfunction

    // Extremes, coincident bodies, unit distances and zero masses.
    task automatic send_directed;
        send_pair(make_pair(-32768, -32768, 32767, 32767, 65535, 65535));
        send_pair(make_pair(32767, 32767, -32768, -32768, 1, 1));
        send_pair(make_pair(0, 0, 0, 0, 5, 7));
        send_pair(make_pair(-32768, 32767, -32768, 32767, 65535, 1));
        send_pair(make_pair(0, 0, 1, 0, 1, 1));
        send_pair(make_pair(0, 0, -1, 0, 65535, 65535));
        send_pair(make_pair(0, 0, 0, 1, 1, 65535));
        send_pair(make_pair(10, 10, 9, 9, 1, 1));
        send_pair(make_pair(0, 0, 3, 4, 0, 9));
        send_pair(make_pair(0, 0, -3, 4, 9, 0));
        send_pair(make_pair(0, 0, 1000, 0, 100, 100));
        send_pair(make_pair(0, 0, 1001, 0, 65535, 65535));
        send_pair(make_pair(-5, 7, 32767, -32768, 99, 101));
        send_pair(make_pair(0, 0, 0, -32768, 65535, 65535));
    endtask

    task automatic run_phase(int n_random, bit long_hold, bit mid_pause);
        send_directed();
        for (int i = 0; i < n_random; i++)
        begin
            if (long_hold && i == 5)
                hold_rx = 1'b1;
            if (mid_pause && i == n_random / 2)
                drain();
            send_pair(random_pair());
        end
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        hold_rx     = 1'b0;
        tx_idle_pct = 10;
        rx_idle_pct = 71;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration, with the long receiver hold-off long enough
        // for the pipeline to fill and stall the sender.
        run_phase(90, 1'b1, 1'b0);

        write_reg(REG_MODE, CFG_W'(MODE_STAR));
        write_reg(REG_COEFF, 34'd65536);
        run_phase(34, 1'b0, 1'b1);

        write_reg(REG_MODE, CFG_W'(MODE_PLANET));
        write_reg(REG_THRESHOLD, 34'd0);
        write_reg(REG_SCALE, 34'd1);
        run_phase(34, 1'b0, 1'b0);

        tx_idle_pct = 71;
        rx_idle_pct = 10;
        write_reg(REG_MODE, 34'd3);
        write_reg(REG_COEFF, 34'd0);
        write_reg(REG_THRESHOLD, 34'h3_FFFF_FFFF);
        run_phase(34, 1'b0, 1'b0);

        write_reg(REG_MODE, CFG_W'(MODE_MUTUAL));
        write_reg(REG_COEFF, 34'h1_FFFF);
        write_reg(REG_THRESHOLD, 34'd8589934592);
        write_reg(REG_SCALE, 34'd1000000);
        run_phase(34, 1'b0, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_MODE, CFG_W'(MODE_STAR));
        write_reg(REG_THRESHOLD, 34'd0);
        write_reg(REG_SCALE, 34'd0);
        run_phase(34, 1'b0, 1'b0);

        write_reg(REG_MODE, CFG_W'(MODE_PLANET));
        write_reg(REG_COEFF, 34'd1);
        write_reg(REG_THRESHOLD, 34'd2000);
        write_reg(REG_SCALE, 34'hF_FFFF);
        run_phase(34, 1'b0, 1'b0);

        write_reg(REG_MODE, CFG_W'(MODE_MUTUAL));
        write_reg(REG_COEFF, 34'd32768);
        write_reg(REG_THRESHOLD, 34'd50000);
        write_reg(REG_SCALE, 34'd10000);
        run_phase(34, 1'b0, 1'b0);

        if (mismatches == 0)
            $display("pairwise_gravity_accel_test: done, clean");
        else
            $display("pairwise_gravity_accel_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pga_pkg.sv
sv/pga_divider.sv
sv/pairwise_gravity_accel.sv
tb/pairwise_gravity_accel_check.sv
tb/pairwise_gravity_accel_test.sv
